// ===== src/eight_bit_isa_execute_unit_core_assert.svh =====
// Assertion macros shared by the execute unit RTL.
`ifndef EIGHT_BIT_ISA_EXECUTE_UNIT_CORE_ASSERT_SVH
`define EIGHT_BIT_ISA_EXECUTE_UNIT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EIU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EIU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/eiu_pkg.sv =====
`default_nettype none

package eiu_pkg;

  localparam int REG_COUNT  = 64;
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int DATA_DEPTH = 64;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int PC_BITS    = 10;
  localparam int TARGET_W   = 10;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_MOVI = 4'd3;
  localparam logic [3:0] OP_BEQZ = 4'd4;
  localparam logic [3:0] OP_ANDI = 4'd5;
  localparam logic [3:0] OP_EOR  = 4'd6;
  localparam logic [3:0] OP_BR   = 4'd7;
  localparam logic [3:0] OP_SAL  = 4'd8;
  localparam logic [3:0] OP_SAR  = 4'd9;
  localparam logic [3:0] OP_LDR  = 4'd10;
  localparam logic [3:0] OP_STR  = 4'd11;

  typedef struct packed {
    logic [15:0] instr_word;
    logic [9:0]  instr_addr;
  } eiu_in_t;

  typedef struct packed {
    logic               branch_taken;
    logic [9:0]         branch_target;
    logic               reg_written;
    logic [5:0]         dest_reg;
    logic signed [7:0]  write_value;
    logic               carry_flag;
    logic               overflow_flag;
    logic               negative_flag;
    logic               sign_flag;
    logic               zero_flag;
  } eiu_out_t;

  typedef struct packed {
    logic c;
    logic v;
    logic n;
    logic s;
    logic z;
  } eiu_flags_t;

endpackage

`default_nettype wire

// ===== src/eiu_alu.sv =====
`default_nettype none

module eiu_alu (
  input  wire eiu_pkg::eiu_in_t    instr,
  input  wire logic [7:0]          a,
  input  wire logic [7:0]          b,
  input  wire logic [7:0]          mem_rdata,
  input  wire eiu_pkg::eiu_flags_t flags,
  output eiu_pkg::eiu_out_t        result,
  output eiu_pkg::eiu_flags_t      flags_next,
  output logic                     store_en
);
  import eiu_pkg::*;

  logic [3:0]         opc;
  logic [5:0]         rs;
  logic [5:0]         rt;
  logic [7:0]         imm;
  logic [8:0]         sum;
  logic [7:0]         diff;
  logic [15:0]        prod;
  logic [2:0]         sar_amt;
  logic [7:0]         res;
  logic               wrote;
  logic               taken;
  logic [PC_BITS-1:0] target;
  logic [7:0]         value;

  assign opc     = instr.instr_word[15:12];
  assign rs      = instr.instr_word[11:6];
  assign rt      = instr.instr_word[5:0];
  assign imm     = {{2{rt[5]}}, rt};
  assign sum     = {1'b0, a} + {1'b0, b};
  assign diff    = a - b;
  assign prod    = {8'd0, a} * {8'd0, b};
  assign sar_amt = (rt >= 6'd7) ? 3'd7 : rt[2:0];

  always_comb begin
    res        = '0;
    wrote      = 1'b0;
    taken      = 1'b0;
    target     = '0;
    store_en   = 1'b0;
    flags_next = flags;
    unique case (opc)
      OP_ADD: begin
        res          = sum[7:0];
        wrote        = 1'b1;
        flags_next.c = sum[8];
        flags_next.v = ~(a[7] ^ b[7]) & (a[7] ^ res[7]);
      end
      OP_SUB: begin
        res          = diff;
        wrote        = 1'b1;
        flags_next.v = (a[7] ^ b[7]) & (a[7] ^ res[7]);
      end
      OP_MUL: begin
        res   = prod[7:0];
        wrote = 1'b1;
      end
      OP_MOVI: begin
        res   = imm;
        wrote = 1'b1;
      end
      OP_BEQZ: begin
        if (a == 8'd0) begin
          taken  = 1'b1;
          target = PC_BITS'(instr.instr_addr) + PC_BITS'(1)
                   + PC_BITS'(signed'(rt));
        end
      end
      OP_ANDI: begin
        res   = a & imm;
        wrote = 1'b1;
      end
      OP_EOR: begin
        res   = a ^ b;
        wrote = 1'b1;
      end
      OP_BR: begin
        taken  = 1'b1;
        target = PC_BITS'({a, 6'b0}) + PC_BITS'(b);
      end
      OP_SAL: begin
        res   = (rt >= 6'd8) ? 8'd0 : (a << rt[2:0]);
        wrote = 1'b1;
      end
      OP_SAR: begin
        res   = 8'($signed(a) >>> sar_amt);
        wrote = 1'b1;
      end
      OP_LDR: begin
        res   = mem_rdata;
        wrote = 1'b1;
      end
      OP_STR: begin
        store_en = 1'b1;
      end
      default: begin
      end
    endcase

    // Every operation that writes a register, apart from a move or a load,
    // recomputes the zero and negative flags.
    if (wrote && (opc != OP_MOVI) && (opc != OP_LDR)) begin
      flags_next.z = (res == 8'd0);
      flags_next.n = res[7];
    end
    if ((opc == OP_ADD) || (opc == OP_SUB)) begin
      flags_next.s = flags_next.n ^ flags_next.v;
    end
  end

  assign value = store_en ? a : res;

  always_comb begin
    result.branch_taken  = taken;
    result.branch_target = TARGET_W'(target);
    result.reg_written   = wrote;
    result.dest_reg      = wrote ? rs : 6'd0;
    result.write_value   = signed'(value);
    result.carry_flag    = flags_next.c;
    result.overflow_flag = flags_next.v;
    result.negative_flag = flags_next.n;
    result.sign_flag     = flags_next.s;
    result.zero_flag     = flags_next.z;
  end

endmodule

`default_nettype wire

// ===== src/eight_bit_isa_execute_unit_core.sv =====
// Execute stage of an eight-bit processor with a 64 x 8 register file and a
// 64-byte data store.
// The instr channel carries one instruction word and its address per
// transaction; the result channel returns exactly one result per instruction,
// in order, holding branch, register write and status flag information.
// Both channels use valid and stall; a transaction completes on a rising edge
// where valid is high and stall is low.
// The register file and data store are read into the execute register when an
// instruction is accepted, and the result register then registers the result.
// Throughput is one instruction per cycle while result_stall is low, set by
// the register file and data store ports, with forwarding of the write made
// on the same edge as the read.
// While the result register is stalled the execute register holds one further
// instruction; only then is instr_stall raised.
// Synchronous reset empties the pipeline and clears the flags; the register
// file and data store read as zero until each entry is first written.
`default_nettype none

module eight_bit_isa_execute_unit_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              instr_valid,
  output logic                   instr_stall,
  input  wire eiu_pkg::eiu_in_t  instr,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output eiu_pkg::eiu_out_t      result
);
  import eiu_pkg::*;

  `include "eight_bit_isa_execute_unit_core_assert.svh"

  logic [7:0]            rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0]  rf_valid;
  logic [7:0]            dm_mem [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] dm_valid;

  logic                  accept;
  logic                  s1_valid;
  logic                  s1_adv;
  logic                  s1_retire;
  eiu_in_t               s1_instr;
  logic [7:0]            ra_q;
  logic [7:0]            rb_q;
  logic [7:0]            dm_q;
  logic                  ra_ok;
  logic                  rb_ok;
  logic                  dm_ok;

  logic                  rbyp_en;
  logic [REG_AW-1:0]     rbyp_addr;
  logic [7:0]            rbyp_data;
  logic                  dbyp_en;
  logic [DATA_AW-1:0]    dbyp_addr;
  logic [7:0]            dbyp_data;

  logic [REG_AW-1:0]     rs_in;
  logic [REG_AW-1:0]     rt_in;
  logic [DATA_AW-1:0]    dm_addr_in;
  logic [REG_AW-1:0]     s1_rs;
  logic [REG_AW-1:0]     s1_rt;
  logic [DATA_AW-1:0]    s1_dm_addr;

  logic [7:0]            op_a;
  logic [7:0]            op_b;
  logic [7:0]            op_mem;
  eiu_flags_t            flags;
  eiu_flags_t            flags_next;
  eiu_out_t              alu_result;
  logic                  store_en;
  logic                  rf_we;
  logic                  dm_we;

  assign s1_adv      = !result_valid || !result_stall;
  assign instr_stall = s1_valid && !s1_adv;
  assign accept      = instr_valid && !instr_stall;
  assign s1_retire   = s1_valid && s1_adv;

  assign rs_in      = instr.instr_word[11:6];
  assign rt_in      = instr.instr_word[5:0];
  assign dm_addr_in = DATA_AW'(instr.instr_word[5:0]);
  assign s1_rs      = s1_instr.instr_word[11:6];
  assign s1_rt      = s1_instr.instr_word[5:0];
  assign s1_dm_addr = DATA_AW'(s1_instr.instr_word[5:0]);

  assign rf_we = s1_retire && alu_result.reg_written;
  assign dm_we = s1_retire && store_en;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[alu_result.dest_reg] <= unsigned'(alu_result.write_value);
    end
    if (accept) begin
      ra_q <= rf_mem[rs_in];
      rb_q <= rf_mem[rt_in];
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[s1_dm_addr] <= op_a;
    end
    if (accept) begin
      dm_q <= dm_mem[dm_addr_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      dm_valid <= '0;
      rbyp_en  <= 1'b0;
      dbyp_en  <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_valid[alu_result.dest_reg] <= 1'b1;
        rbyp_en                       <= 1'b1;
      end
      if (dm_we) begin
        dm_valid[s1_dm_addr] <= 1'b1;
        dbyp_en              <= 1'b1;
      end
    end
  end

  // The bypass registers keep the latest write so that a read made on the
  // same edge as that write still sees the new value.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rbyp_addr <= alu_result.dest_reg;
      rbyp_data <= unsigned'(alu_result.write_value);
    end
    if (dm_we) begin
      dbyp_addr <= s1_dm_addr;
      dbyp_data <= op_a;
    end
    if (accept) begin
      s1_instr <= instr;
      ra_ok    <= rf_valid[rs_in];
      rb_ok    <= rf_valid[rt_in];
      dm_ok    <= dm_valid[dm_addr_in];
    end
  end

  always_comb begin
    if (rbyp_en && (rbyp_addr == s1_rs)) begin
      op_a = rbyp_data;
    end else begin
      op_a = ra_ok ? ra_q : 8'd0;
    end
    if (rbyp_en && (rbyp_addr == s1_rt)) begin
      op_b = rbyp_data;
    end else begin
      op_b = rb_ok ? rb_q : 8'd0;
    end
    if (dbyp_en && (dbyp_addr == s1_dm_addr)) begin
      op_mem = dbyp_data;
    end else begin
      op_mem = dm_ok ? dm_q : 8'd0;
    end
  end

  eiu_alu u_alu (
    .instr      (s1_instr),
    .a          (op_a),
    .b          (op_b),
    .mem_rdata  (op_mem),
    .flags      (flags),
    .result     (alu_result),
    .flags_next (flags_next),
    .store_en   (store_en)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      flags        <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= s1_valid;
      end
      if (s1_retire) begin
        flags <= flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire) begin
      result <= alu_result;
    end
  end

  `EIU_ASSERT_NEXT(a_accept_fills_stage, accept, s1_valid, "accepted transaction lost")
  `EIU_ASSERT_SAME(a_stall_needs_item, instr_stall, s1_valid && result_valid, "stall with empty stage")
  `EIU_ASSERT_SAME(a_no_target_when_not_taken, result_valid && !result.branch_taken, result.branch_target == 10'd0, "target without branch")
  `EIU_ASSERT_SAME(a_branch_excludes_write, result_valid, !(result.branch_taken && result.reg_written), "branch also wrote a register")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
  import eiu_pkg::*;

  localparam logic [3:0] OP_NOP_LO = 4'd12;
  localparam logic [3:0] OP_NOP_HI = 4'd15;

  localparam int N_DIRECTED     = 26;
  localparam int RANDOM_ITEMS   = 800;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    eiu_in_t  ins;
    bit       typed;
    eiu_out_t out;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     instr_valid = 1'b0;
  logic     instr_stall;
  eiu_in_t  instr = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  eiu_out_t result;

  logic [7:0] model_regs [REG_COUNT] = '{default: 8'h00};
  logic [7:0] model_mem [DATA_DEPTH] = '{default: 8'h00};
  eiu_flags_t model_flags = '0;

  stim_row_t   offered_rows [$];
  eiu_out_t    pending_results [$];
  int          fail_count = 0;
  int          accepted_count = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  // Rows with the typed flag set carry a result fixed by hand; the rest are predicted.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{'{{OP_BEQZ, 6'd10, 6'h20}, 10'd0}, 1'b1,
      '{1'b1, 10'd993, 1'b0, 6'd0, 8'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{{OP_BEQZ, 6'd10, 6'h1F}, 10'd1023}, 1'b1,
      '{1'b1, 10'd31, 1'b0, 6'd0, 8'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{{OP_ADD, 6'd0, 6'd0}, 10'd2}, 1'b1,
      '{1'b0, 10'd0, 1'b1, 6'd0, 8'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{{OP_NOP_HI, 6'd63, 6'd63}, 10'd1023}, 1'b1,
      '{1'b0, 10'd0, 1'b0, 6'd0, 8'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{{OP_BR, 6'd0, 6'd0}, 10'd512}, 1'b1,
      '{1'b1, 10'd0, 1'b0, 6'd0, 8'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{{OP_MOVI, 6'd1, 6'h20}, 10'd5}, 1'b0, '0},
    '{'{{OP_MOVI, 6'd2, 6'h1F}, 10'd6}, 1'b0, '0},
    '{'{{OP_MOVI, 6'd63, 6'h3F}, 10'd7}, 1'b0, '0},
    '{'{{OP_ADD, 6'd63, 6'd63}, 10'd8}, 1'b0, '0},
    '{'{{OP_ADD, 6'd2, 6'd2}, 10'd9}, 1'b0, '0},
    '{'{{OP_ADD, 6'd2, 6'd2}, 10'd10}, 1'b0, '0},
    '{'{{OP_ADD, 6'd2, 6'd2}, 10'd11}, 1'b0, '0},
    '{'{{OP_SUB, 6'd1, 6'd2}, 10'd12}, 1'b0, '0},
    '{'{{OP_MUL, 6'd63, 6'd63}, 10'd13}, 1'b0, '0},
    '{'{{OP_ANDI, 6'd1, 6'h2A}, 10'h155}, 1'b0, '0},
    '{'{{OP_STR, 6'd63, 6'd63}, 10'h2AA}, 1'b0, '0},
    '{'{{OP_LDR, 6'd4, 6'd63}, 10'd100}, 1'b0, '0},
    '{'{{OP_BR, 6'd2, 6'd63}, 10'd101}, 1'b0, '0},
    '{'{{OP_BEQZ, 6'd63, 6'h05}, 10'd102}, 1'b0, '0},
    '{'{{OP_SAL, 6'd63, 6'd7}, 10'd103}, 1'b0, '0},
    '{'{{OP_SAL, 6'd2, 6'd8}, 10'd104}, 1'b0, '0},
    '{'{{OP_SAL, 6'd1, 6'd63}, 10'd105}, 1'b0, '0},
    '{'{{OP_SAR, 6'd63, 6'd7}, 10'd106}, 1'b0, '0},
    '{'{{OP_SAR, 6'd4, 6'd63}, 10'd107}, 1'b0, '0},
    '{'{{OP_EOR, 6'd4, 6'd4}, 10'd108}, 1'b0, '0},
    '{'{{OP_NOP_LO, 6'd5, 6'd9}, 10'd109}, 1'b0, '0}
  };

  eight_bit_isa_execute_unit_core dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic eiu_out_t execute_instr(eiu_in_t ins);
    logic [3:0] opc;
    logic [5:0] rs;
    logic [5:0] rt;
    logic [7:0] imm;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] res;
    logic       wrote;
    logic       upd_nz;
    logic       upd_s;
    eiu_out_t   o;
    opc    = ins.instr_word[15:12];
    rs     = ins.instr_word[11:6];
    rt     = ins.instr_word[5:0];
    imm    = {{2{rt[5]}}, rt};
    a      = model_regs[rs];
    b      = model_regs[rt];
    o      = '0;
    res    = '0;
    wrote  = 1'b0;
    upd_nz = 1'b0;
    upd_s  = 1'b0;
    case (opc)
      OP_ADD: begin
        {model_flags.c, res} = {1'b0, a} + {1'b0, b};
        model_flags.v = (a[7] == b[7]) && (res[7] != a[7]);
        {wrote, upd_nz, upd_s} = 3'b111;
      end
      OP_SUB: begin
        res = a - b;
        model_flags.v = (a[7] != b[7]) && (res[7] != a[7]);
        {wrote, upd_nz, upd_s} = 3'b111;
      end
      OP_MUL: begin
        res = a * b;
        {wrote, upd_nz} = 2'b11;
      end
      OP_MOVI: begin
        res = imm;
        wrote = 1'b1;
      end
      OP_BEQZ: begin
        if (a == 8'd0) begin
          o.branch_taken  = 1'b1;
          o.branch_target = ins.instr_addr + 10'd1 + {{2{imm[7]}}, imm};
        end
      end
      OP_ANDI: begin
        res = a & imm;
        {wrote, upd_nz} = 2'b11;
      end
      OP_EOR: begin
        res = a ^ b;
        {wrote, upd_nz} = 2'b11;
      end
      OP_BR: begin
        o.branch_taken  = 1'b1;
        o.branch_target = {a[3:0], 6'd0} + {2'd0, b};
      end
      OP_SAL: begin
        res = (rt >= 6'd8) ? 8'd0 : 8'(a << rt);
        {wrote, upd_nz} = 2'b11;
      end
      OP_SAR: begin
        res = 8'($signed(a) >>> rt);
        {wrote, upd_nz} = 2'b11;
      end
      OP_LDR: begin
        res = model_mem[rt];
        wrote = 1'b1;
      end
      OP_STR: begin
        model_mem[rt] = a;
        o.write_value = a;
      end
      default: begin
      end
    endcase
    if (upd_nz) begin
      model_flags.n = res[7];
      model_flags.z = (res == 8'd0);
    end
    if (upd_s) model_flags.s = model_flags.n ^ model_flags.v;
    if (wrote) begin
      model_regs[rs] = res;
      o.reg_written  = 1'b1;
      o.dest_reg     = rs;
      o.write_value  = res;
    end
    o.carry_flag    = model_flags.c;
    o.overflow_flag = model_flags.v;
    o.negative_flag = model_flags.n;
    o.sign_flag     = model_flags.s;
    o.zero_flag     = model_flags.z;
    return o;
  endfunction

  task automatic offer(input stim_row_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        instr_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    offered_rows.push_back(r);
    instr       <= r.ins;
    instr_valid <= 1'b1;
    @(posedge clk);
    while (instr_stall) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    logic [3:0] opc;
    logic [5:0] rs;
    logic [5:0] rt;
    stim_row_t  row;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) offer(directed_rows[i]);
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) opc = 4'($urandom_range(OP_NOP_LO, OP_NOP_HI));
      else opc = 4'($urandom_range(OP_ADD, OP_STR));
      // A small pool of registers and addresses keeps values flowing between instructions.
      rs = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom);
      rt = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom);
      row.ins.instr_word = {opc, rs, rt};
      row.ins.instr_addr = 10'($urandom);
      row.typed = 1'b0;
      row.out = '0;
      offer(row);
    end
    instr_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("eight_bit_isa_execute_unit_core regression: pass");
    end else begin
      $display("eight_bit_isa_execute_unit_core regression: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    stim_row_t r;
    eiu_out_t  predicted;
    if (!rst && instr_valid && !instr_stall) begin
      r = offered_rows.pop_front();
      predicted = execute_instr(r.ins);
      pending_results.push_back(r.typed ? r.out : predicted);
      accepted_count <= accepted_count + 1;
    end
  end

  always @(posedge clk) begin
    eiu_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no instruction outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("branch_taken", want.branch_taken, result.branch_taken);
        check_field("branch_target", want.branch_target, result.branch_target);
        check_field("reg_written", want.reg_written, result.reg_written);
        check_field("dest_reg", want.dest_reg, result.dest_reg);
        check_field("write_value", $signed(want.write_value), $signed(result.write_value));
        check_field("carry_flag", want.carry_flag, result.carry_flag);
        check_field("overflow_flag", want.overflow_flag, result.overflow_flag);
        check_field("negative_flag", want.negative_flag, result.negative_flag);
        check_field("sign_flag", want.sign_flag, result.sign_flag);
        check_field("zero_flag", want.zero_flag, result.zero_flag);
      end
    end
  end

  // The long hold-off lets the pipeline fill so that the instruction side must stall.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (!hold_done && accepted_count >= HOLD_AT) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  result_stall <= 1'b0;
        STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
        default:     result_stall <= ~result_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (instr_valid && !instr_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("eight_bit_isa_execute_unit_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
